/* sv/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// shared opcodes and defaults for the fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

endpackage

/* sv/fpa_div.sv */
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, one quotient bit per stage, signed fix-up last
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  input  logic        neg,
  output logic [31:0] quo
);

  localparam int unsigned NumW = 32 + FRAC_BITS;

  logic [31:0]     rem_r [1:NumW];
  logic [NumW-1:0] num_r [1:NumW];
  logic [31:0]     quo_r [1:NumW];
  logic [31:0]     den_r [1:NumW];
  logic            neg_r [1:NumW];
  logic [31:0]     q_r;

  for (genvar i = 1; i <= NumW; i++) begin : g_stage
    logic [31:0]     src_rem;
    logic [NumW-1:0] src_num;
    logic [31:0]     src_quo;
    logic [31:0]     src_den;
    logic            src_neg;
    logic [32:0]     t;
    logic            ge;
    logic [31:0]     rem_nxt;

    if (i == 1) begin : g_first
      assign src_rem = '0;
      assign src_num = {mag_a, {FRAC_BITS{1'b0}}};
      assign src_quo = '0;
      assign src_den = mag_b;
      assign src_neg = neg;
    end else begin : g_next
      assign src_rem = rem_r[i-1];
      assign src_num = num_r[i-1];
      assign src_quo = quo_r[i-1];
      assign src_den = den_r[i-1];
      assign src_neg = neg_r[i-1];
    end

    always_comb begin
      t       = {src_rem, src_num[NumW-1]};
      ge      = (t >= {1'b0, src_den});
      rem_nxt = ge ? 32'(t - {1'b0, src_den}) : t[31:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        num_r[i] <= {src_num[NumW-2:0], 1'b0};
        quo_r[i] <= {src_quo[30:0], ge};
        den_r[i] <= src_den;
        neg_r[i] <= src_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[NumW] ? 32'(-quo_r[NumW]) : quo_r[NumW];
    end
  end

  assign quo = q_r;

endmodule

/* sv/fixed_point_alu_unit.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// q-format signed 32-bit alu, fully pipelined around a bit-per-stage divider
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  in      | input     | in_valid/in_stall | req_type, operand_a, operand_b
//  out     | output    | out_valid/out_stall | result_value, compare_true,
//          |           |                   | divide_by_zero
//
//  one word per cycle while in_stall is low
//  the divider yields one quotient bit per stage over 32 + FRAC_BITS
//  stages; other opcodes ride a matching delay line
//  synchronous active-low reset clears the valid bits only
//  out_stall freezes the whole pipeline while a word is at the output; in_stall
//  is high only while a held word sits at the output and out_stall is high
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result_value,
  output logic        out_compare_true,
  output logic        out_divide_by_zero
);

  localparam int unsigned Lat = 32 + FRAC_BITS + 1;

  logic        en;
  logic        v_r [0:Lat];

  fpa_pkg::op_t op0_r;
  logic signed [31:0] a0_r;
  logic signed [31:0] b0_r;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [31:0] quo;

  logic [31:0] s1_res_nxt;
  logic        s1_cmp_nxt;
  logic [31:0] s1_res_r;
  logic        s1_cmp_r;
  logic signed [63:0] s1_prod_r;
  logic        s1_mul_r;
  logic        s1_dz_r;
  logic        s1_div_r;

  logic [31:0] side_res_r [2:Lat];
  logic        side_cmp_r [2:Lat];
  logic        side_dz_r  [2:Lat];
  logic        side_div_r [2:Lat];

  assign en       = !v_r[Lat] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Lat; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= Lat; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= fpa_pkg::op_t'(in_req_type);
      a0_r  <= in_operand_a;
      b0_r  <= in_operand_b;
    end
  end

  // divider operands
  assign mag_a = a0_r[31] ? 32'(-a0_r) : a0_r;
  assign mag_b = b0_r[31] ? 32'(-b0_r) : b0_r;

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .en    (en),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .neg   (a0_r[31] ^ b0_r[31]),
    .quo   (quo)
  );

  always_comb begin
    s1_res_nxt = '0;
    s1_cmp_nxt = 1'b0;
    unique case (op0_r)
      fpa_pkg::OP_ADD:      s1_res_nxt = 32'(a0_r + b0_r);
      fpa_pkg::OP_SUB:      s1_res_nxt = 32'(a0_r - b0_r);
      fpa_pkg::OP_MUL:      s1_res_nxt = '0;
      fpa_pkg::OP_DIV:      s1_res_nxt = '0;
      fpa_pkg::OP_GT:       s1_cmp_nxt = a0_r > b0_r;
      fpa_pkg::OP_LT:       s1_cmp_nxt = a0_r < b0_r;
      fpa_pkg::OP_GE:       s1_cmp_nxt = a0_r >= b0_r;
      fpa_pkg::OP_LE:       s1_cmp_nxt = a0_r <= b0_r;
      fpa_pkg::OP_EQ:       s1_cmp_nxt = a0_r == b0_r;
      fpa_pkg::OP_NE:       s1_cmp_nxt = a0_r != b0_r;
      fpa_pkg::OP_MIN:      s1_res_nxt = (a0_r < b0_r) ? a0_r : b0_r;
      fpa_pkg::OP_MAX:      s1_res_nxt = (a0_r > b0_r) ? a0_r : b0_r;
      fpa_pkg::OP_INC:      s1_res_nxt = 32'(a0_r + 32'sd1);
      fpa_pkg::OP_DEC:      s1_res_nxt = 32'(a0_r - 32'sd1);
      fpa_pkg::OP_TO_INT:   s1_res_nxt = 32'(a0_r >>> FRAC_BITS);
      fpa_pkg::OP_FROM_INT: s1_res_nxt = 32'(a0_r << FRAC_BITS);
      default:              s1_res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_res_r  <= s1_res_nxt;
      s1_cmp_r  <= s1_cmp_nxt;
      s1_prod_r <= 64'(a0_r) * 64'(b0_r);
      s1_mul_r  <= (op0_r == fpa_pkg::OP_MUL);
      s1_div_r  <= (op0_r == fpa_pkg::OP_DIV);
      s1_dz_r   <= (op0_r == fpa_pkg::OP_DIV) && (b0_r == 32'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_res_r[2] <= s1_mul_r ? 32'(s1_prod_r >>> FRAC_BITS) : s1_res_r;
      side_cmp_r[2] <= s1_cmp_r;
      side_dz_r[2]  <= s1_dz_r;
      side_div_r[2] <= s1_div_r;
      for (int k = 3; k <= Lat; k++) begin
        side_res_r[k] <= side_res_r[k-1];
        side_cmp_r[k] <= side_cmp_r[k-1];
        side_dz_r[k]  <= side_dz_r[k-1];
        side_div_r[k] <= side_div_r[k-1];
      end
    end
  end

  assign out_valid          = v_r[Lat];
  assign out_compare_true   = side_cmp_r[Lat];
  assign out_divide_by_zero = side_dz_r[Lat];
  assign out_result_value   = side_dz_r[Lat]  ? 32'sd0 :
                              side_div_r[Lat] ? quo : side_res_r[Lat];

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == 32'sd0)
    else $error("divide by zero word carries a nonzero result");

  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_compare_true && out_divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == 32'sd0)
    else $error("comparison word carries a nonzero result");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted word lost at pipeline entry");

endmodule
